// ----- hdl/edf_pkg.sv -----
package edf_pkg;

  localparam int MaxTasks   = 16;
  localparam int MaxProcs   = 4;
  localparam int ReadyDepth = 32;

  localparam int SlotW = $clog2(MaxTasks);
  localparam int ProcW = $clog2(MaxProcs);
  localparam int PoolW = $clog2(ReadyDepth);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic CFG_ACTIVE_TASKS = 1'b0;
  localparam logic CFG_ACTIVE_PROCS = 1'b1;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] remaining;
    logic [31:0] deadline;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REL_RD,
    ST_REL_WAIT,
    ST_REL_DO,
    ST_SCAN,
    ST_SCAN_END,
    ST_PLACE,
    ST_SCAN2,
    ST_SCAN2_END,
    ST_RUN,
    ST_OUT
  } state_t;

  // true when a beats b: earlier deadline, then lower id
  function automatic logic better(input job_t a, input job_t b);
    if (a.deadline != b.deadline) return a.deadline < b.deadline;
    return a.id < b.id;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ----- hdl/edf_ram.sv -----
module edf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/multiprocessor_edf_scheduler.sv -----
// channel | direction | handshake       | payload
// in_     | input     | valid / stall   | command, slot, task_id, first_release, exec_time, period
// out_    | output    | valid / stall   | processor, busy_res, running_id, started, finished, late,
//         |           |                 | hit/miss/busy counters, ready_overflow, last
// cfg_    | input     | valid / ready   | index, data
// a load writes one task table entry; a tick first takes each active slot through read, wait and
// release steps, then per processor scans the whole ready pool, with a second pass when an idle
// processor picks up a job, then places, runs and outputs a result, and finally advances the tick
// reset clears tick, counters, pool and processor valid bits; the task table is undefined
// a stalled result holds the sequencer, nothing is dropped
module multiprocessor_edf_scheduler (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic [3:0]                in_slot,
  input  logic [7:0]                in_task_id,
  input  logic [15:0]               in_first_release,
  input  logic [15:0]               in_exec_time,
  input  logic [15:0]               in_period,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_processor,
  output logic                      out_busy_res,
  output logic [7:0]                out_running_id,
  output logic                      out_started,
  output logic                      out_finished,
  output logic                      out_late,
  output logic [31:0]               out_hit_count,
  output logic [31:0]               out_miss_count,
  output logic [31:0]               out_busy_ticks,
  output logic                      out_ready_overflow,
  output logic                      out_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [4:0]                cfg_data
);
  import edf_pkg::*;

  state_t state_r, state_nxt;

  logic [4:0]  act_tasks_r;
  logic [2:0]  act_procs_r;
  logic [31:0] tick_r, hits_r, misses_r, busy_r;
  logic        ovf_r;

  logic [ReadyDepth-1:0] pvalid_r;
  job_t                  pool_r [ReadyDepth];
  logic [MaxProcs-1:0]   cvalid_r;
  job_t                  cjob_r [MaxProcs];

  logic [SlotW:0]   slot_r;
  logic [ProcW:0]   proc_r;
  logic [PoolW:0]   idx_r;
  logic             bvalid_r;
  logic [PoolW-1:0] bidx_r;
  job_t             bjob_r;
  logic             started_r;

  // table memory: id, exec, period, next release
  localparam int TabW = 8 + 16 + 16 + 32;
  logic            tab_we;
  logic [SlotW-1:0] tab_waddr;
  logic [TabW-1:0] tab_wdata, tab_rdata;
  logic [7:0]  t_id;
  logic [15:0] t_exec, t_per;
  logic [31:0] t_rel;

  assign {t_id, t_exec, t_per, t_rel} = tab_rdata;

  edf_ram #(.Width(TabW), .Depth(MaxTasks)) u_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (slot_r[SlotW-1:0]),
    .rdata (tab_rdata)
  );

  logic [SlotW:0] ntask;
  logic [ProcW:0] nproc;
  assign ntask = (act_tasks_r > 5'(MaxTasks)) ? (SlotW+1)'(MaxTasks) : (SlotW+1)'(act_tasks_r);
  assign nproc = (act_procs_r > 3'(MaxProcs)) ? (ProcW+1)'(MaxProcs) : (ProcW+1)'(act_procs_r);

  logic in_acc;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);

  // first free pool entry
  logic             free_found;
  logic [PoolW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = ReadyDepth - 1; k >= 0; k--) begin
      if (!pvalid_r[k]) begin
        free_found = 1'b1;
        free_idx   = PoolW'(k);
      end
    end
  end

  logic [ProcW-1:0] pi;
  assign pi = proc_r[ProcW-1:0];
  job_t cur;
  assign cur = cjob_r[pi];
  logic [PoolW-1:0] ii;
  assign ii = idx_r[PoolW-1:0];

  always_comb begin
    state_nxt = state_r;
    tab_we    = 1'b0;
    tab_waddr = in_slot[SlotW-1:0];
    tab_wdata = {in_task_id, in_exec_time, in_period, 16'd0, in_first_release};
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command == CMD_LOAD) tab_we = 1'b1;
          else state_nxt = (ntask == 0) ? ST_SCAN : ST_REL_RD;
        end
      end
      ST_REL_RD:   state_nxt = ST_REL_WAIT;
      ST_REL_WAIT: state_nxt = ST_REL_DO;
      ST_REL_DO: begin
        if (t_rel <= tick_r) begin
          tab_we    = 1'b1;
          tab_waddr = slot_r[SlotW-1:0];
          tab_wdata = {t_id, t_exec, t_per, t_rel + {16'd0, t_per}};
        end
        state_nxt = (slot_r + 1'b1 == ntask) ? ST_SCAN : ST_REL_RD;
      end
      ST_SCAN: begin
        if (proc_r == nproc) state_nxt = ST_IDLE;
        else if (idx_r == (PoolW+1)'(ReadyDepth - 1)) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: state_nxt = (!cvalid_r[pi] && bvalid_r) ? ST_SCAN2 : ST_PLACE;
      ST_SCAN2:    if (idx_r == (PoolW+1)'(ReadyDepth - 1)) state_nxt = ST_PLACE;
      ST_PLACE:    state_nxt = ST_RUN;
      ST_RUN:      state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_SCAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_tasks_r <= '0;
      act_procs_r <= 3'd1;
      tick_r      <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      busy_r      <= '0;
      ovf_r       <= 1'b0;
      pvalid_r    <= '0;
      cvalid_r    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ACTIVE_TASKS) act_tasks_r <= cfg_data;
        else act_procs_r <= cfg_data[2:0];
      end
      case (state_r)
        ST_IDLE: begin
          slot_r   <= '0;
          proc_r   <= '0;
          idx_r    <= '0;
          bvalid_r <= 1'b0;
          started_r <= 1'b0;
        end
        ST_REL_DO: begin
          if (t_rel <= tick_r) begin
            if (free_found) begin
              pvalid_r[free_idx] <= 1'b1;
              pool_r[free_idx]   <= '{id: t_id, remaining: t_exec,
                                      deadline: t_rel + {16'd0, t_per}};
            end else begin
              ovf_r <= 1'b1;
            end
          end
          slot_r <= slot_r + 1'b1;
        end
        ST_SCAN, ST_SCAN2: begin
          if (state_r == ST_SCAN && proc_r == nproc) begin
            tick_r <= tick_r + 32'd1;
          end else begin
            if (pvalid_r[ii] && (!bvalid_r || better(pool_r[ii], bjob_r))) begin
              bvalid_r <= 1'b1;
              bidx_r   <= ii;
              bjob_r   <= pool_r[ii];
            end
            idx_r <= (idx_r == (PoolW+1)'(ReadyDepth - 1)) ? '0 : idx_r + 1'b1;
          end
        end
        ST_SCAN_END: begin
          // idle processor takes the best, then rescans for a swap
          if (!cvalid_r[pi] && bvalid_r) begin
            cvalid_r[pi]     <= 1'b1;
            cjob_r[pi]       <= bjob_r;
            pvalid_r[bidx_r] <= 1'b0;
            started_r        <= 1'b1;
            bvalid_r         <= 1'b0;
          end
        end
        ST_PLACE: begin
          if (cvalid_r[pi] && bvalid_r && better(bjob_r, cur)) begin
            cjob_r[pi]     <= bjob_r;
            pool_r[bidx_r] <= cur;
            started_r      <= 1'b1;
          end
        end
        ST_RUN: begin
          out_processor  <= 2'(proc_r);
          out_started    <= started_r;
          out_busy_res   <= cvalid_r[pi];
          out_running_id <= cvalid_r[pi] ? cur.id : 8'd0;
          out_finished   <= 1'b0;
          out_late       <= 1'b0;
          out_hit_count  <= hits_r;
          out_miss_count <= misses_r;
          out_busy_ticks <= busy_r;
          if (cvalid_r[pi]) begin
            out_busy_ticks <= sat_inc(busy_r);
            busy_r <= sat_inc(busy_r);
            if (cur.remaining <= 16'd1) begin
              cvalid_r[pi] <= 1'b0;
              out_finished <= 1'b1;
              if (cur.deadline < tick_r) begin
                out_late       <= 1'b1;
                misses_r       <= sat_inc(misses_r);
                out_miss_count <= sat_inc(misses_r);
              end else begin
                hits_r        <= sat_inc(hits_r);
                out_hit_count <= sat_inc(hits_r);
              end
            end else begin
              cjob_r[pi].remaining <= cur.remaining - 16'd1;
            end
          end
          out_ready_overflow <= ovf_r;
          out_last  <= (proc_r + 1'b1 == nproc);
          out_valid <= 1'b1;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            proc_r    <= proc_r + 1'b1;
            bvalid_r  <= 1'b0;
            started_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- hdl/edf_checker.sv -----
module edf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_processor,
  input logic        out_busy_res,
  input logic [7:0]  out_running_id,
  input logic        out_finished,
  input logic        out_late,
  input logic        out_ready_overflow
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_processor))
    else $error("result dropped under stall");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> !out_finished && out_running_id == 8'd0)
    else $error("idle processor reports work");
  a_late_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_late |-> out_finished)
    else $error("late without finish");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid) && $past(out_ready_overflow) && out_valid && !$past(out_stall)
    |-> out_ready_overflow)
    else $error("overflow flag cleared");
  // a new request is never taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !out_valid)
    else $error("request accepted with a result pending");
endmodule

bind multiprocessor_edf_scheduler edf_checker u_chk (.*);
